// ===== hw/rtl/wnh_pkg.sv =====
// Shared types, codes and default sizes for the word name histogram.
package wnh_pkg;

    localparam int NAME_COUNT_DEF   = 8;
    localparam int MAX_WORD_LEN_DEF = 16;
    localparam int COUNT_BITS_DEF   = 32;
    localparam int OUT_COUNT_W      = 32;

    // Host command codes carried in a request.
    typedef enum logic [1:0] {
        CMD_WRITE_NAME = 2'd0,
        CMD_TEXT_BYTE  = 2'd1,
        CMD_READ_COUNT = 2'd2,
        CMD_CLEAR_ALL  = 2'd3
    } cmd_t;

    // Operation that travels down the cell chain.
    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_WRITE  = 3'd1,
        OP_LETTER = 3'd2,
        OP_END    = 3'd3,
        OP_READ   = 3'd4,
        OP_CLEAR  = 3'd5
    } op_t;

    typedef struct packed {
        logic [1:0] command;
        logic [2:0] slot;
        logic [3:0] position;
        logic [7:0] char_code;
    } req_t;

    typedef struct packed {
        logic [31:0] count_value;
        logic [2:0]  slot_echo;
    } rsp_t;

    // Control group handed from stage to stage.
    typedef struct packed {
        op_t        op;
        logic       end_ok;
        logic [2:0] slot;
        logic [3:0] position;
        logic [7:0] char_code;
    } chain_ctrl_t;

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

endpackage

// ===== hw/rtl/word_name_histogram.sv =====
// Top level of the word name histogram: head stage, cell chain, response register.
//
// Usage: requests enter on req_valid/req_ready with req_data. A text byte request
// feeds the word splitter; letters extend the open word, any other byte closes
// it and every table entry whose name equals the word bumps its counter, which
// saturates. Write name requests load one name character, clear requests zero
// all counters, and read requests return one response on rsp_valid/rsp_ready
// carrying the counter and the slot. Only read requests produce a response.
//
// Throughput: one request per cycle, sustained, while no response waits with
// rsp_ready low. Every request walks the chain of NAME_COUNT cells one cell per
// cycle while the chain advances; each cell owns one name entry and updates its
// match flag or counter as the request passes, so requests are seen by every
// cell in order. A read request is captured by the head stage, then passes
// through every cell register in turn and then the response register, which
// drives rsp_valid.
// Stall: the whole chain moves as one; when a response waits and rsp_ready is
// low, the chain holds and req_ready drops. A waiting response never blocks a
// new request in the same cycle that it is taken.
// Reset: all names empty, counters zero, no open word; requests are accepted
// as soon as reset is released, since no response waits.
module word_name_histogram #(
    parameter int NAME_COUNT   = wnh_pkg::NAME_COUNT_DEF,
    parameter int MAX_WORD_LEN = wnh_pkg::MAX_WORD_LEN_DEF,
    parameter int COUNT_BITS   = wnh_pkg::COUNT_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  wnh_pkg::req_t req_data,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output wnh_pkg::rsp_t rsp_data
);
    import wnh_pkg::*;

    // Word length must hold the limit itself.
    localparam int LEN_W = $clog2(MAX_WORD_LEN + 1);

    logic advance;

    chain_ctrl_t           ctrl_chain  [NAME_COUNT + 1];
    logic [LEN_W-1:0]      len_chain   [NAME_COUNT + 1];
    logic [COUNT_BITS-1:0] count_chain [NAME_COUNT + 1];

    logic                              rsp_valid_reg, rsp_valid_next;
    rsp_t                              rsp_data_reg;
    logic [OUT_COUNT_W+COUNT_BITS-1:0] count_ext;

    // Advance the whole chain whenever the response register is free or drains.
    assign advance   = !rsp_valid_reg || rsp_ready;
    assign req_ready = advance;

    wnh_word_track #(
        .MAX_WORD_LEN (MAX_WORD_LEN),
        .LEN_W        (LEN_W)
    ) u_track (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .take    (req_valid),
        .req     (req_data),
        .ctrl    (ctrl_chain[0]),
        .len     (len_chain[0])
    );

    // Reads start with a zero count; an out-of-range slot keeps it.
    assign count_chain[0] = '0;

    for (genvar g = 0; g < NAME_COUNT; g++)
    begin : g_cell
        wnh_cell #(
            .CELL_INDEX   (g),
            .MAX_WORD_LEN (MAX_WORD_LEN),
            .COUNT_BITS   (COUNT_BITS),
            .LEN_W        (LEN_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .ctrl_in   (ctrl_chain[g]),
            .len_in    (len_chain[g]),
            .count_in  (count_chain[g]),
            .ctrl_out  (ctrl_chain[g + 1]),
            .len_out   (len_chain[g + 1]),
            .count_out (count_chain[g + 1])
        );
    end

    // Present the low bits of the counter, zero-extended when it is narrow.
    assign count_ext = {{OUT_COUNT_W{1'b0}}, count_chain[NAME_COUNT]};

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (advance)
        begin
            rsp_valid_next = (ctrl_chain[NAME_COUNT].op == OP_READ);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Capture the response payload as it leaves the last cell.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rsp_data_reg.count_value <= count_ext[OUT_COUNT_W-1:0];
            rsp_data_reg.slot_echo   <= ctrl_chain[NAME_COUNT].slot;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule

// ===== hw/rtl/wnh_word_track.sv =====
// Head stage: track the open word and turn requests into chain operations.
module wnh_word_track #(
    parameter int MAX_WORD_LEN = 16,
    parameter int LEN_W        = 5
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic                 take,
    input  wnh_pkg::req_t        req,
    output wnh_pkg::chain_ctrl_t ctrl,
    output logic [LEN_W-1:0]     len
);
    import wnh_pkg::*;

    logic [LEN_W-1:0] word_len_reg, word_len_next;
    logic             too_long_reg, too_long_next;
    chain_ctrl_t      ctrl_reg, ctrl_next;
    logic [LEN_W-1:0] len_reg, len_next;

    always_comb
    begin
        word_len_next       = word_len_reg;
        too_long_next       = too_long_reg;
        ctrl_next           = ctrl_reg;
        len_next            = len_reg;
        if (advance)
        begin
            ctrl_next.op        = OP_NONE;
            ctrl_next.end_ok    = 1'b0;
            ctrl_next.slot      = req.slot;
            ctrl_next.position  = req.position;
            ctrl_next.char_code = req.char_code;
            len_next            = word_len_reg;
            if (take)
            begin
                unique case (cmd_t'(req.command))
                    CMD_WRITE_NAME: ctrl_next.op = OP_WRITE;
                    CMD_TEXT_BYTE:
                    begin
                        if (is_letter(req.char_code))
                        begin
                            // Past the limit: mark the word dead and send nothing.
                            if (too_long_reg || (32'(word_len_reg) >= MAX_WORD_LEN))
                            begin
                                too_long_next = 1'b1;
                            end
                            else
                            begin
                                ctrl_next.op  = OP_LETTER;
                                word_len_next = word_len_reg + LEN_W'(1);
                            end
                        end
                        else
                        begin
                            ctrl_next.op     = OP_END;
                            ctrl_next.end_ok = (word_len_reg != '0) && !too_long_reg;
                            word_len_next    = '0;
                            too_long_next    = 1'b0;
                        end
                    end
                    CMD_READ_COUNT: ctrl_next.op = OP_READ;
                    CMD_CLEAR_ALL:  ctrl_next.op = OP_CLEAR;
                    default:        ctrl_next.op = OP_NONE;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_len_reg <= '0;
            too_long_reg <= 1'b0;
            ctrl_reg     <= '{op: OP_NONE, default: '0};
        end
        else
        begin
            word_len_reg <= word_len_next;
            too_long_reg <= too_long_next;
            ctrl_reg     <= ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg <= len_next;
    end

    assign ctrl = ctrl_reg;
    assign len  = len_reg;

endmodule

// ===== hw/rtl/wnh_cell.sv =====
// One chain cell: a name entry, its match flag and its saturating counter.
module wnh_cell #(
    parameter int CELL_INDEX   = 0,
    parameter int MAX_WORD_LEN = 16,
    parameter int COUNT_BITS   = 32,
    parameter int LEN_W        = 5
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  wnh_pkg::chain_ctrl_t  ctrl_in,
    input  logic [LEN_W-1:0]      len_in,
    input  logic [COUNT_BITS-1:0] count_in,
    output wnh_pkg::chain_ctrl_t  ctrl_out,
    output logic [LEN_W-1:0]      len_out,
    output logic [COUNT_BITS-1:0] count_out
);
    import wnh_pkg::*;

    localparam int IDX_W = $clog2(MAX_WORD_LEN);

    logic [7:0]            name_reg [MAX_WORD_LEN];
    logic                  match_reg, match_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    chain_ctrl_t           ctrl_reg;
    logic [LEN_W-1:0]      len_reg;
    logic [COUNT_BITS-1:0] pass_reg, pass_next;

    logic             hit;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [7:0]       rd_char;
    logic             at_limit;

    assign hit      = (32'(ctrl_in.slot) == CELL_INDEX);
    assign wr_idx   = IDX_W'(ctrl_in.position);
    assign wr_en    = advance && (ctrl_in.op == OP_WRITE) && hit &&
                      (32'(ctrl_in.position) < MAX_WORD_LEN);
    assign at_limit = (32'(len_in) >= MAX_WORD_LEN);
    assign rd_char  = at_limit ? 8'h00 : name_reg[len_in[IDX_W-1:0]];

    always_comb
    begin
        match_next = match_reg;
        cnt_next   = cnt_reg;
        pass_next  = count_in;
        case (ctrl_in.op)
            OP_LETTER:
            begin
                if (rd_char != ctrl_in.char_code)
                begin
                    match_next = 1'b0;
                end
            end
            OP_END:
            begin
                if (ctrl_in.end_ok && match_reg && (at_limit || (rd_char == 8'h00)) &&
                    !(&cnt_reg))
                begin
                    cnt_next = cnt_reg + COUNT_BITS'(1);
                end
                match_next = 1'b1;
            end
            OP_READ:
            begin
                if (hit)
                begin
                    pass_next = cnt_reg;
                end
            end
            OP_CLEAR: cnt_next = '0;
            default:  ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b1;
            cnt_reg   <= '0;
            ctrl_reg  <= '{op: OP_NONE, default: '0};
            for (int i = 0; i < MAX_WORD_LEN; i++)
            begin
                name_reg[i] <= 8'h00;
            end
        end
        else if (advance)
        begin
            match_reg <= match_next;
            cnt_reg   <= cnt_next;
            ctrl_reg  <= ctrl_in;
            if (wr_en)
            begin
                name_reg[wr_idx] <= ctrl_in.char_code;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            len_reg  <= len_in;
            pass_reg <= pass_next;
        end
    end

    assign ctrl_out  = ctrl_reg;
    assign len_out   = len_reg;
    assign count_out = pass_reg;

endmodule
